[design/pivl_pkg.sv]
// ---------------------------------------------------------------------------
// pivl_pkg
// Shared types, register codes, reset values and the control program of the
// voltage-loop PI controller.
// ---------------------------------------------------------------------------
package pivl_pkg;

   localparam int STEP_W = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 24;

   typedef logic [STEP_W-1:0] step_type;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PROP_GAIN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_UPPER_LIMIT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LOWER_LIMIT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ADC_SCALE     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ADC_OFFSET    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_PWM_PERIOD    = 3'd6;

   // reset values
   localparam logic [23:0] PROP_GAIN_RST     = 24'd94381;
   localparam logic [23:0] INTEGRAL_GAIN_RST = 24'd34256;
   localparam logic [16:0] UPPER_LIMIT_RST   = 17'd58982;
   localparam logic [16:0] LOWER_LIMIT_RST   = 17'd0;
   localparam logic [23:0] ADC_SCALE_RST     = 24'd82936;
   localparam logic [15:0] ADC_OFFSET_RST    = 16'd341;
   localparam logic [15:0] PWM_PERIOD_RST    = 16'd3333;

   // item opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   // clamp codes
   localparam logic [1:0] CLAMP_NONE = 2'd0;
   localparam logic [1:0] CLAMP_HIGH = 2'd1;
   localparam logic [1:0] CLAMP_LOW  = 2'd2;

   typedef struct packed {
      logic [23:0] prop_gain;
      logic [23:0] integral_gain;
      logic [16:0] upper_limit;
      logic [16:0] lower_limit;
      logic [23:0] adc_scale;
      logic [15:0] adc_offset;
      logic [15:0] pwm_period;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] error_value;
      logic [1:0]         clamp_state;
      logic [16:0]        control_value;
      logic [15:0]        duty_count;
   } result_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_ADC,
      MUL_KI,
      MUL_KP,
      MUL_DUTY
   } mul_sel_type;

   typedef enum logic [2:0] {
      ALU_NOP,
      ALU_MEAS,
      ALU_ERR,
      ALU_ROUND,
      ALU_INTEG,
      ALU_RAW,
      ALU_CLAMP
   } alu_op_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_SKIP_INTEG,
      COND_END
   } cond_type;

   typedef struct packed {
      mul_sel_type mul;
      alu_op_type  alu;
      cond_type    cond;
      step_type    target;
   } ctl_word_type;

   typedef struct packed {
      logic busy;
      logic finish;
   } seq_status_type;

   localparam ctl_word_type CTL_IDLE = '{mul: MUL_NONE, alu: ALU_NOP, cond: COND_NEXT,
                                         target: '0};

   // control program, one word per step
   function automatic ctl_word_type ucode(input step_type step);
      ctl_word_type w;
      w = CTL_IDLE;
      unique case (step)
         4'd0:  w.mul = MUL_ADC;
         4'd1:  w.alu = ALU_MEAS;
         4'd2:  w.alu = ALU_ERR;
         4'd3: begin
            w.mul    = MUL_KI;
            w.cond   = COND_SKIP_INTEG;
            w.target = 4'd6;
         end
         4'd4:  w.alu = ALU_ROUND;
         4'd5:  w.alu = ALU_INTEG;
         4'd6:  w.mul = MUL_KP;
         4'd7:  w.alu = ALU_ROUND;
         4'd8:  w.alu = ALU_RAW;
         4'd9:  w.alu = ALU_CLAMP;
         4'd10: w.mul = MUL_DUTY;
         4'd11: w.cond = COND_END;
         default: w.cond = COND_END;
      endcase
      return w;
   endfunction

endpackage

[design/pivl_ram.sv]
// ---------------------------------------------------------------------------
// pivl_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pivl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/pivl_sequencer.sv]
// ---------------------------------------------------------------------------
// pivl_sequencer
// Step counter over the control program, with the conditional skip of the
// integrator update and the hold of the last step while the output is full.
// ---------------------------------------------------------------------------
module pivl_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    integ_en,
   input  logic                    out_free,
   output pivl_pkg::ctl_word_type  ctl,
   output pivl_pkg::seq_status_type status
);

   logic               busy_ff, busy_in;
   pivl_pkg::step_type step_ff, step_in;
   pivl_pkg::ctl_word_type word;
   logic               finish;

   assign word = pivl_pkg::ucode(step_ff);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      finish  = 1'b0;
      if (busy_ff) begin
         unique case (word.cond)
            pivl_pkg::COND_END: begin
               if (out_free) begin
                  finish  = 1'b1;
                  busy_in = 1'b0;
                  step_in = '0;
               end
            end
            pivl_pkg::COND_SKIP_INTEG: begin
               step_in = integ_en ? step_ff + 1'b1 : word.target;
            end
            default: step_in = step_ff + 1'b1;
         endcase
      end else if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign ctl           = busy_ff ? word : pivl_pkg::CTL_IDLE;
   assign status.busy   = busy_ff;
   assign status.finish = finish;

   a_finish_on_end: assert property (@(posedge clock) disable iff (reset)
      finish |-> busy_ff && word.cond == pivl_pkg::COND_END)
      else $error("finish outside the end step");

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("start while a sample is in progress");

endmodule

[design/pivl_datapath.sv]
// ---------------------------------------------------------------------------
// pivl_datapath
// Shared multiplier and ALU of the PI step: scaling, error, rounding,
// integrator with saturation, output clamp and duty count.
// ---------------------------------------------------------------------------
module pivl_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  pivl_pkg::ctl_word_type ctl,
   input  pivl_pkg::cfg_type      cfg,
   input  logic [11:0]            adc_sample,
   input  logic [15:0]            ref_volts,
   output logic                   integ_en,
   output pivl_pkg::result_type   result
);

   logic signed [32:0] mul_a;
   logic [23:0]        mul_b;
   logic signed [57:0] prod_ff, prod_in;
   logic signed [57:0] round_sum;
   logic [35:0]        meas_sum;
   logic signed [33:0] err_diff;
   logic signed [33:0] integ_sum;
   logic [17:0]        duty_full;

   logic signed [28:0] meas_ff, meas_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [32:0] gm_ff, gm_in;
   logic signed [31:0] integ_ff, integ_in;
   logic signed [33:0] raw_ff, raw_in;
   logic [16:0]        ctrl_ff, ctrl_in;
   logic [1:0]         clamp_ff, clamp_in;
   logic               integ_en_ff, integ_en_in;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic ovf;
      ovf = (v[33:31] != 3'b000) && (v[33:31] != 3'b111);
      if (!ovf) begin
         return v[31:0];
      end
      return v[33] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
   endfunction

   always_comb begin
      unique case (ctl.mul)
         pivl_pkg::MUL_ADC: begin
            mul_a = $signed({21'd0, adc_sample});
            mul_b = cfg.adc_scale;
         end
         pivl_pkg::MUL_KI: begin
            mul_a = $signed({err_ff[31], err_ff});
            mul_b = cfg.integral_gain;
         end
         pivl_pkg::MUL_KP: begin
            mul_a = $signed({err_ff[31], err_ff});
            mul_b = cfg.prop_gain;
         end
         pivl_pkg::MUL_DUTY: begin
            mul_a = $signed({16'd0, ctrl_ff});
            mul_b = {8'd0, cfg.pwm_period};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in   = mul_a * $signed({1'b0, mul_b});
   assign round_sum = prod_ff + (prod_ff[57] ? 58'sd8388607 : 58'sd8388608);
   assign meas_sum  = prod_ff[35:0] + 36'd128;
   assign err_diff  = $signed({2'b00, ref_volts, 16'd0}) - 34'(meas_ff);
   assign integ_sum = 34'(integ_ff) + 34'(gm_ff);
   assign duty_full = prod_ff[33:16];

   always_comb begin
      meas_in     = meas_ff;
      err_in      = err_ff;
      gm_in       = gm_ff;
      integ_in    = integ_ff;
      raw_in      = raw_ff;
      ctrl_in     = ctrl_ff;
      clamp_in    = clamp_ff;
      integ_en_in = integ_en_ff;
      unique case (ctl.alu)
         pivl_pkg::ALU_MEAS:
            meas_in = $signed({1'b0, meas_sum[35:8]}) - $signed({13'd0, cfg.adc_offset});
         pivl_pkg::ALU_ERR:   err_in   = sat32(err_diff);
         pivl_pkg::ALU_ROUND: gm_in    = round_sum[56:24];
         pivl_pkg::ALU_INTEG: integ_in = sat32(integ_sum);
         pivl_pkg::ALU_RAW:   raw_in   = 34'(gm_ff) + 34'(integ_ff);
         pivl_pkg::ALU_CLAMP: begin
            if (raw_ff > $signed({17'd0, cfg.upper_limit})) begin
               ctrl_in     = cfg.upper_limit;
               clamp_in    = pivl_pkg::CLAMP_HIGH;
               integ_en_in = 1'b0;
            end else if (raw_ff < $signed({17'd0, cfg.lower_limit})) begin
               ctrl_in     = cfg.lower_limit;
               clamp_in    = pivl_pkg::CLAMP_LOW;
               integ_en_in = 1'b0;
            end else begin
               ctrl_in     = raw_ff[16:0];
               clamp_in    = pivl_pkg::CLAMP_NONE;
               integ_en_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.mul != pivl_pkg::MUL_NONE) begin
         prod_ff <= prod_in;
      end
      meas_ff  <= meas_in;
      err_ff   <= err_in;
      gm_ff    <= gm_in;
      raw_ff   <= raw_in;
      ctrl_ff  <= ctrl_in;
      clamp_ff <= clamp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         integ_en_ff <= 1'b1;
      end else begin
         integ_ff    <= integ_in;
         integ_en_ff <= integ_en_in;
      end
   end

   assign integ_en             = integ_en_ff;
   assign result.error_value   = err_ff;
   assign result.clamp_state   = clamp_ff;
   assign result.control_value = ctrl_ff;
   assign result.duty_count    = (duty_full[17:16] != 2'b00) ? 16'hFFFF : duty_full[15:0];

endmodule

[design/pi_voltage_loop_antiwindup_top.sv]
// ---------------------------------------------------------------------------
// pi_voltage_loop_antiwindup_top
// Voltage-loop PI controller with conditional-integration anti-windup,
// sequenced by a microcoded control program over one shared multiplier.
//
//  channel  dir  handshake              payload
//  req_     in   req_tvalid/req_tready   req_tdata, req_tuser (opcode)
//  rsp_     out  rsp_tvalid/rsp_tready   rsp_tdata
//  csr_     in   csr_we                  csr_index, csr_wdata
//
// A load item is written to the table when accepted, if its slot lies in the
// table. A sample item runs the steps of the control program from accept to
// result and skips the integrator update steps when the integrator is frozen.
// No clearing pass after reset: table entries are undefined until loaded.
// A finished result waits in the output register; the last program step
// holds while that register is full, and no item is taken meanwhile.
// ---------------------------------------------------------------------------
module pi_voltage_loop_antiwindup_top #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // adc_sample[11:0], table_slot[19:12], table_volts[35:20]
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // duty_count[15:0], control_value[32:16],
                                    // clamp_state[34:33], error_value[66:35]
   input  logic        csr_we,
   input  logic [pivl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pivl_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [11:0] req_sample;
   logic [7:0]  req_slot;
   logic [15:0] req_volts;
   logic        accept, start, load_we, out_free;

   pivl_pkg::cfg_type        cfg_ff, cfg_in;
   pivl_pkg::ctl_word_type   ctl;
   pivl_pkg::seq_status_type seq_status;
   pivl_pkg::result_type     dp_result;
   pivl_pkg::result_type     rsp_data_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]            pos_ff, pos_in;
   logic [11:0]              sample_ff;
   logic [15:0]              ref_volts;
   logic                     integ_en;

   assign req_sample = req_tdata[11:0];
   assign req_slot   = req_tdata[19:12];
   assign req_volts  = req_tdata[35:20];

   assign req_tready = !seq_status.busy;
   assign accept     = req_tvalid && req_tready;
   assign start      = accept && (req_tuser == pivl_pkg::OP_SAMPLE);
   assign load_we    = accept && (req_tuser == pivl_pkg::OP_LOAD)
                       && (int'(req_slot) < TABLE_DEPTH);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pivl_pkg::REG_PROP_GAIN:     cfg_in.prop_gain     = csr_wdata;
            pivl_pkg::REG_INTEGRAL_GAIN: cfg_in.integral_gain = csr_wdata;
            pivl_pkg::REG_UPPER_LIMIT:   cfg_in.upper_limit   = csr_wdata[16:0];
            pivl_pkg::REG_LOWER_LIMIT:   cfg_in.lower_limit   = csr_wdata[16:0];
            pivl_pkg::REG_ADC_SCALE:     cfg_in.adc_scale     = csr_wdata;
            pivl_pkg::REG_ADC_OFFSET:    cfg_in.adc_offset    = csr_wdata[15:0];
            pivl_pkg::REG_PWM_PERIOD:    cfg_in.pwm_period    = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain     <= pivl_pkg::PROP_GAIN_RST;
         cfg_ff.integral_gain <= pivl_pkg::INTEGRAL_GAIN_RST;
         cfg_ff.upper_limit   <= pivl_pkg::UPPER_LIMIT_RST;
         cfg_ff.lower_limit   <= pivl_pkg::LOWER_LIMIT_RST;
         cfg_ff.adc_scale     <= pivl_pkg::ADC_SCALE_RST;
         cfg_ff.adc_offset    <= pivl_pkg::ADC_OFFSET_RST;
         cfg_ff.pwm_period    <= pivl_pkg::PWM_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // advance table position on each finished sample
   always_comb begin
      pos_in = pos_ff;
      if (seq_status.finish) begin
         pos_in = (pos_ff == AW'(TABLE_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seq_status.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sample_ff <= req_sample;
      end
      if (seq_status.finish) begin
         rsp_data_ff <= dp_result;
      end
   end

   pivl_ram #(
      .WIDTH (16),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (load_we),
      .waddr (AW'(req_slot)),
      .wdata (req_volts),
      .re    (start),
      .raddr (pos_ff),
      .rdata (ref_volts)
   );

   pivl_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .integ_en (integ_en),
      .out_free (out_free),
      .ctl      (ctl),
      .status   (seq_status)
   );

   pivl_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .cfg        (cfg_ff),
      .adc_sample (sample_ff),
      .ref_volts  (ref_volts),
      .integ_en   (integ_en),
      .result     (dp_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff.error_value, rsp_data_ff.clamp_state,
                        rsp_data_ff.control_value, rsp_data_ff.duty_count};

   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      start |=> seq_status.busy)
      else $error("sample item did not start the program");

   a_clamp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.clamp_state == pivl_pkg::CLAMP_NONE ||
                        rsp_data_ff.clamp_state == pivl_pkg::CLAMP_HIGH ||
                        rsp_data_ff.clamp_state == pivl_pkg::CLAMP_LOW))
      else $error("illegal clamp state");

   a_clamp_high_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.clamp_state == pivl_pkg::CLAMP_HIGH
      |-> rsp_data_ff.control_value == cfg_ff.upper_limit)
      else $error("clamped high output differs from upper limit");

endmodule

[bench/pi_voltage_loop_antiwindup_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pi_voltage_loop_antiwindup_checker
// Watches the request, result and register ports of the voltage-loop PI
// controller. Keeps its own copy of the setpoint table, integrator, freeze
// flag and registers, predicts each sample result and compares every result
// field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module pi_voltage_loop_antiwindup_checker #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // adc_sample[11:0], table_slot[19:12], table_volts[35:20]
   input  logic        req_tuser,   // opcode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,   // duty_count[15:0], control_value[32:16],
                                    // clamp_state[34:33], error_value[66:35]
   input  logic        csr_we,
   input  logic [pivl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pivl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int          mismatches,
   output int          pending_results,
   output int          results_checked
);

   pivl_pkg::cfg_type    loop_cfg;
   logic [15:0]          setpoint_table [TABLE_DEPTH];
   int                   table_pos;
   logic signed [31:0]   integ_acc;
   logic                 integ_enable;
   pivl_pkg::result_type expected_outputs [$];
   pivl_pkg::result_type got;
   pivl_pkg::result_type want;
   int                   error_total;
   int                   checked_total;

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Q0.24 gain times Q16.16 value, round half away from zero
   function automatic longint gain_round(input longint x, input longint g);
      longint p;
      p = x * g;
      if (p >= 0) return (p + 64'sh800000) >>> 24;
      return -(((-p) + 64'sh800000) >>> 24);
   endfunction

   function automatic pivl_pkg::result_type step_loop(input logic [11:0] adc_val);
      longint               measured;
      longint               err;
      longint               raw;
      longint               ctrl;
      longint               duty;
      pivl_pkg::result_type r;
      measured = ((longint'(adc_val) * longint'(loop_cfg.adc_scale) + 128) >>> 8)
                 - longint'(loop_cfg.adc_offset);
      err = clip32(longint'(setpoint_table[table_pos]) * 65536 - measured);
      if (integ_enable)
         integ_acc = 32'(clip32(longint'(integ_acc)
                                + gain_round(err, longint'(loop_cfg.integral_gain))));
      raw = gain_round(err, longint'(loop_cfg.prop_gain)) + longint'(integ_acc);
      if (raw > longint'(loop_cfg.upper_limit)) begin
         ctrl = longint'(loop_cfg.upper_limit);
         r.clamp_state = pivl_pkg::CLAMP_HIGH;
         integ_enable = 1'b0;
      end else if (raw < longint'(loop_cfg.lower_limit)) begin
         ctrl = longint'(loop_cfg.lower_limit);
         r.clamp_state = pivl_pkg::CLAMP_LOW;
         integ_enable = 1'b0;
      end else begin
         ctrl = raw;
         r.clamp_state = pivl_pkg::CLAMP_NONE;
         integ_enable = 1'b1;
      end
      duty = (longint'(loop_cfg.pwm_period) * ctrl) >>> 16;
      if (duty > 65535) duty = 65535;
      table_pos = (table_pos + 1 >= TABLE_DEPTH) ? 0 : table_pos + 1;
      r.duty_count    = duty[15:0];
      r.control_value = ctrl[16:0];
      r.error_value   = err[31:0];
      return r;
   endfunction

   task automatic report_field(input string field, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
         error_total++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         loop_cfg.prop_gain     = pivl_pkg::PROP_GAIN_RST;
         loop_cfg.integral_gain = pivl_pkg::INTEGRAL_GAIN_RST;
         loop_cfg.upper_limit   = pivl_pkg::UPPER_LIMIT_RST;
         loop_cfg.lower_limit   = pivl_pkg::LOWER_LIMIT_RST;
         loop_cfg.adc_scale     = pivl_pkg::ADC_SCALE_RST;
         loop_cfg.adc_offset    = pivl_pkg::ADC_OFFSET_RST;
         loop_cfg.pwm_period    = pivl_pkg::PWM_PERIOD_RST;
         for (int i = 0; i < TABLE_DEPTH; i++) setpoint_table[i] = '0;
         table_pos = 0;
         integ_acc = '0;
         integ_enable = 1'b1;
         expected_outputs.delete();
         error_total = 0;
         checked_total = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               pivl_pkg::REG_PROP_GAIN:     loop_cfg.prop_gain     = csr_wdata[23:0];
               pivl_pkg::REG_INTEGRAL_GAIN: loop_cfg.integral_gain = csr_wdata[23:0];
               pivl_pkg::REG_UPPER_LIMIT:   loop_cfg.upper_limit   = csr_wdata[16:0];
               pivl_pkg::REG_LOWER_LIMIT:   loop_cfg.lower_limit   = csr_wdata[16:0];
               pivl_pkg::REG_ADC_SCALE:     loop_cfg.adc_scale     = csr_wdata[23:0];
               pivl_pkg::REG_ADC_OFFSET:    loop_cfg.adc_offset    = csr_wdata[15:0];
               pivl_pkg::REG_PWM_PERIOD:    loop_cfg.pwm_period    = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = pivl_pkg::result_type'(rsp_tdata[66:0]);
            if (expected_outputs.size() == 0) begin
               $display("%0t: result with none expected, actual %h", $time, rsp_tdata);
               error_total++;
            end else begin
               want = expected_outputs.pop_front();
               report_field("duty_count", want.duty_count, got.duty_count);
               report_field("control_value", want.control_value, got.control_value);
               report_field("clamp_state", want.clamp_state, got.clamp_state);
               report_field("error_value", want.error_value, got.error_value);
               checked_total++;
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == pivl_pkg::OP_LOAD) begin
               if (int'(req_tdata[19:12]) < TABLE_DEPTH)
                  setpoint_table[req_tdata[19:12]] = req_tdata[35:20];
            end else begin
               expected_outputs.push_back(step_loop(req_tdata[11:0]));
            end
         end
      end
      mismatches      <= error_total;
      pending_results <= expected_outputs.size();
      results_checked <= checked_total;
   end

endmodule

[bench/pi_voltage_loop_antiwindup_top_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pi_voltage_loop_antiwindup_top_tb
// Drives sample and load items into the voltage-loop PI controller in random
// bursts under several register settings, including all-zero, all-max,
// crossed limits and duty overflow, while the result side stalls at random
// and once per selected setting holds off for a long stretch. The checker
// beside the block predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module pi_voltage_loop_antiwindup_top_tb;

   localparam int TABLE_DEPTH = 256;
   localparam int NUM_SETTINGS = 8;
   localparam int ITEMS_PER_SETTING = 165;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [pivl_pkg::CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [pivl_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pivl_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   int mismatches;
   int pending_results;
   int results_checked;

   bit          slot_written [TABLE_DEPTH];
   logic [15:0] setpoint_copy [TABLE_DEPTH];
   int          next_pos = 0;
   longint      cur_scale = longint'(pivl_pkg::ADC_SCALE_RST);
   longint      cur_offset = longint'(pivl_pkg::ADC_OFFSET_RST);
   int          sample_items = 0;
   int          load_items = 0;
   int          settings_done = 0;

   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int run_left = 0;
   int ready_kind = 0;

   pi_voltage_loop_antiwindup_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pi_voltage_loop_antiwindup_checker #(.TABLE_DEPTH(TABLE_DEPTH)) loop_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .pending_results(pending_results),
      .results_checked(results_checked)
   );

   always #4 clock = ~clock;

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // result side: random ready runs, long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            if (run_left == 0) begin
               ready_kind = $urandom_range(0, 3);
               run_left = $urandom_range(8, 120);
            end
            run_left--;
            case (ready_kind)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ~rsp_tready;
            endcase
         end
         @(posedge clock);
      end
   end

   function automatic logic [15:0] pick_volts();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 8) return 16'($urandom_range(0, 24));
      if (roll == 8) return 16'($urandom_range(0, 65535));
      return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
   endfunction

   // track the setpoint in half of the picks so the loop spends time inside its limits
   function automatic logic [11:0] pick_adc(input logic [15:0] target);
      int     roll;
      longint want;
      roll = $urandom_range(0, 9);
      if (roll < 5 && cur_scale != 0) begin
         want = (((longint'(target) <<< 16) + cur_offset) <<< 8) / cur_scale;
         want = want + longint'($urandom_range(0, 16)) - 8;
         if (want < 0) want = 0;
         if (want > 4095) want = 4095;
         return want[11:0];
      end
      if (roll == 9) return ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
      return 12'($urandom_range(0, 4095));
   endfunction

   task automatic send_item(input logic op, input logic [11:0] adc_val,
                            input logic [7:0] slot, input logic [15:0] volts);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, volts, slot, adc_val};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_load(input int slot, input logic [15:0] volts);
      send_item(pivl_pkg::OP_LOAD, 12'($urandom_range(0, 4095)), slot[7:0], volts);
      slot_written[slot] = 1'b1;
      setpoint_copy[slot] = volts;
      load_items++;
   endtask

   // negative adc_val: pick one at random
   task automatic send_sample(input int adc_val);
      logic [11:0] a;
      if (!slot_written[next_pos]) send_load(next_pos, pick_volts());
      a = (adc_val < 0) ? pick_adc(setpoint_copy[next_pos]) : adc_val[11:0];
      send_item(pivl_pkg::OP_SAMPLE, a, 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)));
      next_pos = (next_pos + 1) % TABLE_DEPTH;
      sample_items++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic apply_setting(input int which);
      logic [pivl_pkg::CSR_DATA_W-1:0] v [7];
      v[pivl_pkg::REG_PROP_GAIN]     = pivl_pkg::PROP_GAIN_RST;
      v[pivl_pkg::REG_INTEGRAL_GAIN] = pivl_pkg::INTEGRAL_GAIN_RST;
      v[pivl_pkg::REG_UPPER_LIMIT]   = 24'(pivl_pkg::UPPER_LIMIT_RST);
      v[pivl_pkg::REG_LOWER_LIMIT]   = 24'(pivl_pkg::LOWER_LIMIT_RST);
      v[pivl_pkg::REG_ADC_SCALE]     = pivl_pkg::ADC_SCALE_RST;
      v[pivl_pkg::REG_ADC_OFFSET]    = 24'(pivl_pkg::ADC_OFFSET_RST);
      v[pivl_pkg::REG_PWM_PERIOD]    = 24'(pivl_pkg::PWM_PERIOD_RST);
      case (which)
         0: for (int i = 0; i < 7; i++) v[i] = '0;
         1: begin
            v[pivl_pkg::REG_PROP_GAIN]     = 24'hFFFFFF;
            v[pivl_pkg::REG_INTEGRAL_GAIN] = 24'hFFFFFF;
            v[pivl_pkg::REG_UPPER_LIMIT]   = 24'd65536;
            v[pivl_pkg::REG_LOWER_LIMIT]   = 24'd65536;
            v[pivl_pkg::REG_ADC_SCALE]     = 24'hFFFFFF;
            v[pivl_pkg::REG_ADC_OFFSET]    = 24'h00FFFF;
            v[pivl_pkg::REG_PWM_PERIOD]    = 24'h00FFFF;
         end
         2: begin
            v[pivl_pkg::REG_PROP_GAIN]     = 24'h200000;
            v[pivl_pkg::REG_INTEGRAL_GAIN] = 24'h080000;
         end
         3: begin
            v[pivl_pkg::REG_UPPER_LIMIT] = 24'd1000;
            v[pivl_pkg::REG_LOWER_LIMIT] = 24'd60000;
         end
         4: begin
            v[pivl_pkg::REG_PROP_GAIN]   = 24'h400000;
            v[pivl_pkg::REG_UPPER_LIMIT] = 24'h01FFFF;
            v[pivl_pkg::REG_PWM_PERIOD]  = 24'h00FFFF;
         end
         5, 6: begin
            v[pivl_pkg::REG_PROP_GAIN]     = 24'($urandom_range(0, 24'h800000));
            v[pivl_pkg::REG_INTEGRAL_GAIN] = 24'($urandom_range(0, 24'h200000));
            v[pivl_pkg::REG_UPPER_LIMIT]   = 24'($urandom_range(32768, 65536));
            v[pivl_pkg::REG_LOWER_LIMIT]   = 24'($urandom_range(0, 16384));
            v[pivl_pkg::REG_ADC_SCALE]     = 24'($urandom_range(60000, 120000));
            v[pivl_pkg::REG_ADC_OFFSET]    = 24'($urandom_range(0, 4000));
            v[pivl_pkg::REG_PWM_PERIOD]    = 24'($urandom_range(1000, 65535));
         end
         default: ;
      endcase
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[pivl_pkg::CSR_INDEX_W-1:0];
         csr_wdata <= v[i];
         @(posedge clock);
      end
      if (which == 0) begin
         csr_we    <= 1'b1;
         csr_index <= REG_UNUSED;
         csr_wdata <= 24'hFFFFFF;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
      cur_scale = longint'(v[pivl_pkg::REG_ADC_SCALE]);
      cur_offset = longint'(v[pivl_pkg::REG_ADC_OFFSET]);
      settings_done++;
   endtask

   task automatic run_random(input int count);
      int n;
      int burst;
      int gap;
      n = 0;
      burst = 0;
      while (n < count) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         if ($urandom_range(0, 3) == 0) send_load($urandom_range(0, TABLE_DEPTH - 1),
                                                  pick_volts());
         else send_sample(-1);
         n++;
         burst--;
      end
   endtask

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         slot_written[i] = 1'b0;
         setpoint_copy[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: zero setpoint, saturated error, frozen integrator, extremes
      send_load(0, 16'h0000);
      send_sample(0);
      send_load(1, 16'hFFFF);
      send_sample(4095);
      send_load(2, 16'h0000);
      send_sample(4095);
      send_load(3, 16'd10);
      send_sample(-1);
      send_load(TABLE_DEPTH - 1, 16'hFFFF);
      send_load(4, 16'd20);
      send_sample(0);
      send_sample(2048);
      send_sample(4095);
      send_sample(0);
      send_sample(-1);
      send_sample(-1);

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         wait_idle();
         apply_setting(s);
         if (s == 2 || s == 5) hold_asked++;
         run_random(ITEMS_PER_SETTING);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d sample and %0d load items over %0d register settings",
               sample_items, load_items, settings_done);
      $display("checked %0d results, %0d mismatches, %0d results outstanding",
               results_checked, mismatches, pending_results);
      if (mismatches == 0 && pending_results == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
